[design/rgt_pkg.sv]
// shared types and constants for the rotating grille transposer
// no dependencies; imported by every module of the block
package rgt_pkg;

  // fixed geometry
  localparam int SYM_W       = 21;
  localparam int MAX_SIDE    = 4;
  localparam int ROTATIONS   = 4;
  localparam int CELLS       = MAX_SIDE * MAX_SIDE;
  localparam int STORE_DEPTH = 64;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int CNT_W       = STORE_AW + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int STATUS_W    = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRILLE_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_ENABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_SYMBOL  = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LENGTH    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERLAP   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNCOVERED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_GRID_SIZE = 3'd5;

  // input transaction
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [SYM_W-1:0]    out_symbol;
    logic                out_last;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // configuration register file contents
  typedef struct packed {
    logic [2:0]       grid_size;
    logic [CELLS-1:0] grille_mask;
    logic             direction;
    logic             pad_enable;
    logic [SYM_W-1:0] pad_symbol;
  } cfg_t;

  // symbol store access from the sequencer
  typedef struct packed {
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [SYM_W-1:0]    wr_data;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
  } ram_req_t;

endpackage

[design/rotating_grille_transposer_core.sv]
// rotating grille transposer, top level
// depends on rgt_pkg, rgt_cfg, rgt_ram and rgt_ctrl
//
// usage: symbols enter on the in_ channel one transaction per cycle and are
// written into a 64-entry symbol store until a transaction with last set.
// in_stall is high from then on until the whole result burst has been issued.
// encode: a check state, then a placement scan over the rotations, a fill
// check state, then n*n results at one per cycle unless out_stall holds them.
// decode: a check state, then a scan over the rotations that issues one result
// per hole position, straight from the store's single read port.
// an error gives a single result with out_last set and a nonzero status.
// results pass a store read stage, then an output register. out_stall holds
// both and pauses emission and the decode scan at holes, nothing is dropped.
// configuration is written through cfg_we/cfg_index/cfg_wdata while idle:
// the user is bound to this, the block itself does not enforce it.
// synchronous reset puts the registers at their reset values and clears the
// load count and cell flags; the symbol store needs no clearing.
module rotating_grille_transposer_core import rgt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SYM_W-1:0]     cfg_wdata
);

  cfg_t             cfg;
  ram_req_t         ram_req;
  logic [SYM_W-1:0] ram_rd_data;

  rgt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rgt_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  rgt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

endmodule

[design/rgt_cfg.sv]
// configuration registers of the rotating grille transposer
// depends on rgt_pkg for the register indexes and cfg_t
module rgt_cfg import rgt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SYM_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_size   <= 3'd4;
      cfg_r.grille_mask <= '0;
      cfg_r.direction   <= 1'b0;
      cfg_r.pad_enable  <= 1'b0;
      cfg_r.pad_symbol  <= SYM_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_SIZE:   cfg_r.grid_size   <= cfg_wdata[2:0];
        REG_GRILLE_MASK: cfg_r.grille_mask <= cfg_wdata[CELLS-1:0];
        REG_DIRECTION:   cfg_r.direction   <= cfg_wdata[0];
        REG_PAD_ENABLE:  cfg_r.pad_enable  <= cfg_wdata[0];
        REG_PAD_SYMBOL:  cfg_r.pad_symbol  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[design/rgt_ram.sv]
// symbol store: one write port, one read port, registered read data
// depends on rgt_pkg for ram_req_t and the store geometry
module rgt_ram import rgt_pkg::*; (
  input  logic             clk,
  input  ram_req_t         req,
  output logic [SYM_W-1:0] rd_data
);

  logic [SYM_W-1:0] mem [STORE_DEPTH];
  logic [SYM_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read port, data holds between reads
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/rgt_ctrl.sv]
// sequencer: load, length checks, placement scan, emission and output stage
// depends on rgt_pkg; drives the symbol store through ram_req_t
module rgt_ctrl import rgt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  output ram_req_t         ram_req,
  input  logic [SYM_W-1:0] ram_rd_data
);

  // sequencer states
  localparam logic [2:0] S_LOAD    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_PLACE   = 3'd2;
  localparam logic [2:0] S_FILLCHK = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;
  localparam logic [2:0] S_DREAD   = 3'd5;
  localparam logic [2:0] S_ERR     = 3'd6;

  // kinds of entries in the read stage
  localparam logic [1:0] K_MEM = 2'd0;
  localparam logic [1:0] K_PAD = 2'd1;
  localparam logic [1:0] K_ERR = 2'd2;

  localparam int CELL_W = $clog2(CELLS);
  localparam int POS_W  = $clog2(MAX_SIDE);

  // n times a row or column index, n being 2, 3 or 4
  function automatic logic [CELL_W-1:0] mul_n(input logic [2:0] n, input logic [POS_W-1:0] x);
    logic [CELL_W-1:0] xe;
    logic [CELL_W-1:0] res;
    xe = CELL_W'(x);
    case (n)
      3'd2:    res = xe << 1;
      3'd3:    res = (xe << 1) + xe;
      default: res = xe << 2;
    endcase
    return res;
  endfunction

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    lc_r, lc_nxt;
  logic                ovf_r, ovf_nxt;
  logic [1:0]          rot_r, rot_nxt;
  logic [POS_W-1:0]    row_r, row_nxt;
  logic [POS_W-1:0]    col_r, col_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    ecnt_r, ecnt_nxt;
  logic [CNT_W-1:0]    cap_r, cap_nxt;
  logic [STATUS_W-1:0] err_r, err_nxt;
  logic [CELL_W-1:0]   cell_r, cell_nxt;
  logic [CELLS-1:0]    filled_r, filled_nxt;
  logic [STORE_AW-1:0] src_r [CELLS];

  logic                src_we;
  logic [CELL_W-1:0]   src_waddr;
  logic [STORE_AW-1:0] src_wdata;

  // read stage and output register
  logic                s1_valid_r, s1_valid_nxt;
  logic [1:0]          s1_kind_r;
  logic                s1_last_r;
  logic [STATUS_W-1:0] s1_status_r;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r;

  logic                issue;
  logic [1:0]          iss_kind;
  logic                iss_last;
  logic [STATUS_W-1:0] iss_status;
  logic [STORE_AW-1:0] iss_addr;

  logic pop, move, issue_ok;

  // grid geometry from the configured side
  logic [2:0]         n;
  logic [POS_W-1:0]   nm1;
  logic [CELL_W:0]    ncells;
  logic [CELLS-1:0]   cell_mask;
  logic [CELL_W:0]    holes;
  logic [CNT_W-1:0]   cap;

  always_comb begin
    if (cfg.grid_size < 3'd2) begin
      n = 3'd2;
    end else if (cfg.grid_size > 3'(MAX_SIDE)) begin
      n = 3'(MAX_SIDE);
    end else begin
      n = cfg.grid_size;
    end
    nm1 = POS_W'(n - 3'd1);
    case (n)
      3'd2:    ncells = (CELL_W+1)'(4);
      3'd3:    ncells = (CELL_W+1)'(9);
      default: ncells = (CELL_W+1)'(16);
    endcase
    holes = '0;
    for (int k = 0; k < CELLS; k++) begin
      cell_mask[k] = ((CELL_W+1)'(k) < ncells);
      holes = holes + (CELL_W+1)'(cfg.grille_mask[k] & cell_mask[k]);
    end
    cap = CNT_W'(holes) << 2;
  end

  // scan position, rotated source cell and hole test
  logic [CELL_W-1:0] scan_cell;
  logic [POS_W-1:0]  si, sj;
  logic [CELL_W-1:0] src_bit;
  logic              hole;
  logic              scan_end;

  always_comb begin
    scan_cell = mul_n(n, row_r) + CELL_W'(col_r);
    case (rot_r)
      2'd0: begin
        si = row_r;
        sj = col_r;
      end
      2'd1: begin
        si = nm1 - col_r;
        sj = row_r;
      end
      2'd2: begin
        si = nm1 - row_r;
        sj = nm1 - col_r;
      end
      default: begin
        si = col_r;
        sj = nm1 - row_r;
      end
    endcase
    src_bit  = mul_n(n, si) + CELL_W'(sj);
    hole     = cfg.grille_mask[src_bit];
    scan_end = (rot_r == 2'd3) && (row_r == nm1) && (col_r == nm1);
  end

  // handshake of the read stage and output register
  assign pop      = out_valid_r && !out_stall;
  assign move     = s1_valid_r && (!out_valid_r || pop);
  assign issue_ok = !s1_valid_r || move;
  assign in_stall = (state_r != S_LOAD);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    lc_nxt     = lc_r;
    ovf_nxt    = ovf_r;
    rot_nxt    = rot_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    idx_nxt    = idx_r;
    ecnt_nxt   = ecnt_r;
    cap_nxt    = cap_r;
    err_nxt    = err_r;
    cell_nxt   = cell_r;
    filled_nxt = filled_r;
    src_we     = 1'b0;
    src_waddr  = scan_cell;
    src_wdata  = idx_r[STORE_AW-1:0];
    issue      = 1'b0;
    iss_kind   = K_MEM;
    iss_last   = 1'b0;
    iss_status = ST_OK;
    iss_addr   = src_r[cell_r];
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = lc_r[STORE_AW-1:0];
    ram_req.wr_data = in_data.symbol;

    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (lc_r < CNT_W'(STORE_DEPTH)) begin
            ram_req.wr_en = 1'b1;
            lc_nxt = lc_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last) begin
            state_nxt = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        rot_nxt  = '0;
        row_nxt  = '0;
        col_nxt  = '0;
        idx_nxt  = '0;
        ecnt_nxt = '0;
        cap_nxt  = cap;
        if (!cfg.direction) begin
          if (cfg.pad_enable && (ovf_r || lc_r > cap)) begin
            err_nxt   = ST_TOO_LONG;
            state_nxt = S_ERR;
          end else if (!cfg.pad_enable && (ovf_r || lc_r != cap)) begin
            err_nxt   = ST_LENGTH;
            state_nxt = S_ERR;
          end else begin
            state_nxt = S_PLACE;
          end
        end else if (ovf_r || lc_r != CNT_W'(ncells)) begin
          err_nxt   = ST_GRID_SIZE;
          state_nxt = S_ERR;
        end else if (holes == '0) begin
          lc_nxt     = '0;
          ovf_nxt    = 1'b0;
          filled_nxt = '0;
          state_nxt  = S_LOAD;
        end else begin
          state_nxt = S_DREAD;
        end
      end

      // one grid position per cycle, recording which symbol lands where
      S_PLACE: begin
        if (hole && filled_r[scan_cell]) begin
          err_nxt   = ST_OVERLAP;
          state_nxt = S_ERR;
        end else begin
          if (hole && (idx_r < lc_r)) begin
            filled_nxt[scan_cell] = 1'b1;
            src_we  = 1'b1;
            idx_nxt = idx_r + 1'b1;
          end
          if (scan_end) begin
            state_nxt = S_FILLCHK;
          end
        end
      end

      S_FILLCHK: begin
        cell_nxt = '0;
        if (!cfg.pad_enable && ((cell_mask & ~filled_r) != '0)) begin
          err_nxt   = ST_UNCOVERED;
          state_nxt = S_ERR;
        end else begin
          state_nxt = S_EMIT;
        end
      end

      // grid out row-major, empty cells take the pad symbol
      S_EMIT: begin
        if (issue_ok) begin
          issue    = 1'b1;
          iss_kind = filled_r[cell_r] ? K_MEM : K_PAD;
          iss_addr = src_r[cell_r];
          iss_last = ((CELL_W+1)'(cell_r) == ncells - 1'b1);
          if (iss_last) begin
            lc_nxt     = '0;
            ovf_nxt    = 1'b0;
            filled_nxt = '0;
            state_nxt  = S_LOAD;
          end else begin
            cell_nxt = cell_r + 1'b1;
          end
        end
      end

      // holes read in rotation order, straight from the grid store
      S_DREAD: begin
        iss_addr = STORE_AW'(scan_cell);
        if (hole && issue_ok) begin
          issue    = 1'b1;
          iss_kind = K_MEM;
          iss_last = (ecnt_r == cap_r - 1'b1);
          ecnt_nxt = ecnt_r + 1'b1;
        end
        if (!hole || issue_ok) begin
          if (scan_end) begin
            lc_nxt     = '0;
            ovf_nxt    = 1'b0;
            filled_nxt = '0;
            state_nxt  = S_LOAD;
          end
        end
      end

      S_ERR: begin
        if (issue_ok) begin
          issue      = 1'b1;
          iss_kind   = K_ERR;
          iss_last   = 1'b1;
          iss_status = err_r;
          lc_nxt     = '0;
          ovf_nxt    = 1'b0;
          filled_nxt = '0;
          state_nxt  = S_LOAD;
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // step the rotation/row/column scan
    if ((state_r == S_PLACE && !(hole && filled_r[scan_cell])) ||
        (state_r == S_DREAD && (!hole || issue_ok))) begin
      if (col_r == nm1) begin
        col_nxt = '0;
        if (row_r == nm1) begin
          row_nxt = '0;
          rot_nxt = rot_r + 1'b1;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end

    ram_req.rd_en   = issue;
    ram_req.rd_addr = iss_addr;

    s1_valid_nxt  = issue ? 1'b1 : (move ? 1'b0 : s1_valid_r);
    out_valid_nxt = move ? 1'b1 : (pop ? 1'b0 : out_valid_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      lc_r        <= '0;
      ovf_r       <= 1'b0;
      filled_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rot_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      idx_r       <= '0;
      ecnt_r      <= '0;
      cap_r       <= '0;
      err_r       <= ST_OK;
      cell_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      lc_r        <= lc_nxt;
      ovf_r       <= ovf_nxt;
      filled_r    <= filled_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      rot_r       <= rot_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      idx_r       <= idx_nxt;
      ecnt_r      <= ecnt_nxt;
      cap_r       <= cap_nxt;
      err_r       <= err_nxt;
      cell_r      <= cell_nxt;
    end
  end

  // per-cell source index of the placed symbol
  always_ff @(posedge clk) begin
    if (src_we) begin
      src_r[src_waddr] <= src_wdata;
    end
  end

  // read stage tag, registered alongside the store's read data
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_kind_r   <= iss_kind;
      s1_last_r   <= iss_last;
      s1_status_r <= iss_status;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (move) begin
      case (s1_kind_r)
        K_MEM:   out_data_r.out_symbol <= ram_rd_data;
        K_PAD:   out_data_r.out_symbol <= cfg.pad_symbol;
        default: out_data_r.out_symbol <= '0;
      endcase
      out_data_r.out_last <= s1_last_r;
      out_data_r.status   <= s1_status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/rotating_grille_transposer_core_tb.sv]
// self-checking testbench for rotating_grille_transposer_core
// depends on rgt_pkg and the core; predicts every result transaction and checks it on the fly
`timescale 1ns / 100ps

module rotating_grille_transposer_core_tb;
  import rgt_pkg::*;

  localparam logic [SYM_W-1:0]     SYM_MAX      = 21'd1114111;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 3'd7;
  localparam int                   RANDOM_ITEMS = 420;
  // worst burst: check, placement scan, fill check, n*n results, read and output stages
  localparam int                   DRAIN_CYCLES = 120;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SYM_W-1:0]     cfg_wdata = '0;

  // predictor copy of the registers
  logic [2:0]       cfg_side_raw = 3'd4;
  logic [15:0]      cfg_mask     = 16'h0000;
  bit               cfg_decode   = 1'b0;
  bit               cfg_pad_en   = 1'b0;
  logic [SYM_W-1:0] cfg_pad_sym  = 21'd32;

  // predictor copy of the data path state
  logic [SYM_W-1:0] sym_mem    [STORE_DEPTH];
  logic [SYM_W-1:0] grid_cells [CELLS];
  bit               cell_taken [CELLS];
  int               fill_count = 0;
  bit               overrun    = 1'b0;

  out_item_t grille_expect [$];
  out_item_t want;

  int  mismatches      = 0;
  int  results_checked = 0;
  int  items_sent      = 0;
  int  sets_done       = 0;
  int  reg_writes      = 0;
  int  status_hits [8];
  int  stall_left      = 0;
  bit  steady_flow     = 1'b0;

  rotating_grille_transposer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("%0t: run timed out with %0d results outstanding", $time, grille_expect.size());
    $display("rotating_grille_transposer_core_tb failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int side_len();
    if (cfg_side_raw < 3'd2) return 2;
    if (cfg_side_raw > 3'(MAX_SIDE)) return MAX_SIDE;
    return int'(cfg_side_raw);
  endfunction

  function automatic int hole_count();
    int n, c, total;
    n = side_len();
    total = 0;
    for (c = 0; c < n * n; c++) total += int'(cfg_mask[c]);
    return total;
  endfunction

  // cell (i,j) is open after rot clockwise quarter turns of the grille
  function automatic bit hole_at(int n, int rot, int i, int j);
    int r, ti;
    for (r = 0; r < rot; r++) begin
      ti = n - 1 - j;
      j  = i;
      i  = ti;
    end
    return cfg_mask[(i * n + j) & 15];
  endfunction

  function automatic void push_result(logic [SYM_W-1:0] sym, bit lst, logic [STATUS_W-1:0] st);
    out_item_t r;
    r.out_symbol = sym;
    r.out_last   = lst;
    r.status     = st;
    grille_expect.push_back(r);
    status_hits[st]++;
  endfunction

  // encode: length check, placement over the rotations, then coverage
  function automatic logic [STATUS_W-1:0] lay_message(int n, int holes);
    int cap, idx, c, rot, i, j;
    cap = holes * ROTATIONS;
    idx = 0;
    if (cfg_pad_en) begin
      if (overrun || fill_count > cap) return ST_TOO_LONG;
    end else if (overrun || fill_count != cap) begin
      return ST_LENGTH;
    end
    for (rot = 0; rot < ROTATIONS; rot++)
      for (i = 0; i < n; i++)
        for (j = 0; j < n; j++) begin
          c = i * n + j;
          if (!hole_at(n, rot, i, j)) continue;
          if (cell_taken[c]) return ST_OVERLAP;
          if (idx < fill_count) begin
            grid_cells[c] = sym_mem[idx];
            cell_taken[c] = 1'b1;
            idx++;
          end
        end
    for (c = 0; c < n * n; c++) begin
      if (!cell_taken[c]) begin
        if (!cfg_pad_en) return ST_UNCOVERED;
        grid_cells[c] = cfg_pad_sym;
      end
    end
    return ST_OK;
  endfunction

  // one accepted input transaction; a last mark releases the burst
  function automatic void grille_predict(in_item_t t);
    int n, holes, c, rot, i, j, k;
    logic [STATUS_W-1:0] st;
    if (fill_count < STORE_DEPTH) begin
      sym_mem[fill_count] = t.symbol;
      fill_count++;
    end else begin
      overrun = 1'b1;
    end
    if (!t.last) return;
    n     = side_len();
    holes = hole_count();
    if (cfg_decode) begin
      if (overrun || fill_count != n * n) begin
        push_result('0, 1'b1, ST_GRID_SIZE);
      end else begin
        k = 0;
        for (rot = 0; rot < ROTATIONS; rot++)
          for (i = 0; i < n; i++)
            for (j = 0; j < n; j++)
              if (hole_at(n, rot, i, j)) begin
                push_result(sym_mem[(i * n + j) & (STORE_DEPTH - 1)],
                            k == holes * ROTATIONS - 1, ST_OK);
                k++;
              end
      end
    end else begin
      st = lay_message(n, holes);
      if (st != ST_OK) begin
        push_result('0, 1'b1, st);
      end else begin
        for (c = 0; c < n * n; c++) push_result(grid_cells[c], c == n * n - 1, ST_OK);
      end
    end
    fill_count = 0;
    overrun    = 1'b0;
    for (c = 0; c < CELLS; c++) cell_taken[c] = 1'b0;
    sets_done++;
  endfunction

  function automatic void store_config(logic [CFG_IDX_W-1:0] idx, logic [SYM_W-1:0] val);
    case (idx)
      REG_GRID_SIZE:   cfg_side_raw = val[2:0];
      REG_GRILLE_MASK: cfg_mask     = val[15:0];
      REG_DIRECTION:   cfg_decode   = val[0];
      REG_PAD_ENABLE:  cfg_pad_en   = val[0];
      REG_PAD_SYMBOL:  cfg_pad_sym  = val;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- random helpers

  // mostly short idle runs, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // one hole per rotation orbit gives a grille that covers every cell once, bar the center of an odd grid
  function automatic logic [15:0] make_grille(int n);
    logic [15:0] m;
    bit          seen [16];
    int          orbit [4];
    int          c, k, i, j, ti;
    m = '0;
    for (c = 0; c < 16; c++) seen[c] = 1'b0;
    for (c = 0; c < n * n; c++) begin
      if (seen[c]) continue;
      i = c / n;
      j = c % n;
      for (k = 0; k < 4; k++) begin
        orbit[k] = i * n + j;
        seen[orbit[k]] = 1'b1;
        ti = n - 1 - j;
        j  = i;
        i  = ti;
      end
      // the center of an odd grid maps onto itself and stays closed
      if (orbit[1] == orbit[0]) continue;
      m[orbit[$urandom_range(0, 3)]] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [15:0] pick_mask(int n);
    int          r;
    logic [15:0] m;
    logic [31:0] wide, rnd;
    r    = $urandom_range(0, 99);
    m    = make_grille(n);
    wide = ~((32'h1 << (n * n)) - 32'h1);
    rnd  = $urandom;
    if (r < 55) return m;
    // junk in bits past the grid
    if (r < 70) return m | (wide[15:0] & rnd[15:0]);
    if (r < 80) return rnd[15:0];
    if (r < 85) return 16'h0000;
    if (r < 90) return 16'hFFFF;
    // one hole added or removed
    return m ^ (16'h1 << $urandom_range(0, n * n - 1));
  endfunction

  function automatic logic [SYM_W-1:0] pick_symbol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return SYM_MAX;
    return SYM_W'($urandom_range(0, 1114111));
  endfunction

  // mostly well-formed lengths for the current setting, some broken and a few overflows
  function automatic int pick_set_len();
    int r, n, cap, good;
    n   = side_len();
    cap = hole_count() * ROTATIONS;
    if (cfg_decode) good = n * n;
    else if (cfg_pad_en) good = (cap > 0) ? $urandom_range(1, cap) : 1;
    else good = (cap > 0) ? cap : 1;
    r = $urandom_range(0, 99);
    if (r < 78) return good;
    if (r < 88) return good + 1;
    if (r < 92 && good > 1) return good - 1;
    if (r < 97) return $urandom_range(1, 20);
    return $urandom_range(65, 68);
  endfunction

  // random bits above a register's width, half of the time
  function automatic logic [SYM_W-1:0] with_junk(logic [SYM_W-1:0] v, int w);
    logic [SYM_W-1:0] hi;
    hi = SYM_W'($urandom);
    if ($urandom_range(0, 1) == 0) return v;
    return (hi << w) | v;
  endfunction

  // ---------------------------------------------------------------- drivers

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
      stall_left = idle_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_symbol(logic [SYM_W-1:0] sym, bit lst);
    int gap;
    gap = (!steady_flow && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {sym, lst};
    do @(posedge clk); while (in_stall);
    items_sent++;
    grille_predict({sym, lst});
  endtask

  task automatic send_set(int len);
    int k;
    for (k = 0; k < len; k++) send_symbol(pick_symbol(), k == len - 1);
  endtask

  // hold input until every result is out and the block has gone quiet
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (grille_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SYM_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    store_config(idx, val);
    reg_writes++;
  endtask

  task automatic set_config(logic [2:0] gs, logic [15:0] mask, bit dir, bit pad,
                            logic [SYM_W-1:0] psym);
    wait_drained();
    cfg_write(REG_GRID_SIZE,   with_junk(SYM_W'(gs), 3));
    cfg_write(REG_GRILLE_MASK, with_junk(SYM_W'(mask), 16));
    cfg_write(REG_DIRECTION,   with_junk(SYM_W'(dir), 1));
    cfg_write(REG_PAD_ENABLE,  with_junk(SYM_W'(pad), 1));
    cfg_write(REG_PAD_SYMBOL,  psym);
  endtask

  // ---------------------------------------------------------------- result checker

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (grille_expect.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = grille_expect.pop_front();
        if (out_data.out_symbol !== want.out_symbol) begin
          $display("%0t: out_symbol expected %h actual %h", $time, want.out_symbol,
                   out_data.out_symbol);
          mismatches++;
        end
        if (out_data.out_last !== want.out_last) begin
          $display("%0t: out_last expected %b actual %b", $time, want.out_last,
                   out_data.out_last);
          mismatches++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_data.status);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // reset setting: 4x4, no holes, encode without padding, so any message is a length error
  task automatic test_reset_state();
    send_symbol(SYM_MAX, 1'b1);
  endtask

  // single-hole 2x2 encode with extreme symbols
  task automatic test_encode_small();
    set_config(3'd2, 16'h0001, 1'b0, 1'b0, '0);
    send_symbol(SYM_MAX, 1'b0);
    send_symbol('0, 1'b0);
    send_symbol(21'h0F0000, 1'b0);
    send_symbol(21'h10AAAA, 1'b1);
  endtask

  // side below range acts as 2, mask bits past the grid are ignored, spare index ignored
  task automatic test_decode_small();
    set_config(3'd0, 16'hFFF1, 1'b1, 1'b0, SYM_MAX);
    cfg_write(REG_SPARE, SYM_W'($urandom));
    send_set(4);
  endtask

  task automatic test_error_codes();
    // two holes in one orbit collide
    set_config(3'd2, 16'h0003, 1'b0, 1'b1, '0);
    send_set(1);
    // padded message longer than the grille holds
    set_config(3'd2, 16'h0001, 1'b0, 1'b1, SYM_MAX);
    send_set(5);
    // right length but the grille leaves cells open
    set_config(3'd3, 16'h0001, 1'b0, 1'b0, 21'd32);
    send_set(4);
    // decode with a short grid
    set_config(3'd4, 16'hFFFF, 1'b1, 1'b0, 21'd32);
    send_set(3);
  endtask

  // side above range acts as 4, short message padded out
  task automatic test_padding();
    set_config(3'd7, make_grille(4), 1'b0, 1'b1, SYM_MAX);
    send_set(5);
  endtask

  task automatic test_random_sets();
    int sent, r, n, s, nsets, len;
    logic [2:0]       gs;
    logic [SYM_W-1:0] psym;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 10) gs = 3'($urandom_range(0, 1));
      else if (r < 20) gs = 3'($urandom_range(5, 7));
      else gs = 3'($urandom_range(2, 4));
      n = (gs < 3'd2) ? 2 : ((gs > 3'd4) ? 4 : int'(gs));
      r = $urandom_range(0, 99);
      if (r < 10) psym = '0;
      else if (r < 20) psym = SYM_MAX;
      else psym = SYM_W'($urandom_range(0, 1114111));
      set_config(gs, pick_mask(n), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), psym);
      steady_flow = ($urandom_range(0, 4) == 0);
      nsets = $urandom_range(1, 4);
      for (s = 0; s < nsets && sent < RANDOM_ITEMS; s++) begin
        len = pick_set_len();
        send_set(len);
        sent += len;
        // sometimes hold the sender until the burst has fully drained
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
    end
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_encode_small();
    test_decode_small();
    test_error_codes();
    test_padding();
    test_random_sets();
    wait_drained();

    $display("covered %0d input transactions in %0d data sets with %0d register writes",
             items_sent, sets_done, reg_writes);
    $display("checked %0d results: ok %0d, length %0d, too long %0d, overlap %0d,",
             results_checked, status_hits[ST_OK], status_hits[ST_LENGTH],
             status_hits[ST_TOO_LONG], status_hits[ST_OVERLAP]);
    $display("  uncovered %0d, grid %0d", status_hits[ST_UNCOVERED], status_hits[ST_GRID_SIZE]);
    if (mismatches == 0 && grille_expect.size() == 0) begin
      $display("rotating_grille_transposer_core_tb passed");
    end else begin
      $display("rotating_grille_transposer_core_tb failed");
    end
    $finish;
  end

endmodule
